>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

>>> hdl/jddm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jddm_pkg;

  localparam int AXIS_WIDTH_DEF = 8;
  localparam int DUTY_W         = 8;
  localparam int FRAC_BITS      = 8;
  localparam int GAIN_W         = 16;
  localparam int DIV_STEPS      = DUTY_W;

  // 50/127 in unsigned Q0.16
  localparam logic [GAIN_W-1:0] GAIN_Q16 = 16'd25802;

  localparam logic [DUTY_W-1:0] OFFSET_RST = 8'd50;
  localparam logic [DUTY_W-1:0] LIMIT_RST  = 8'd100;

  typedef enum logic [1:0] {
    DIR_FWD  = 2'd0,
    DIR_BWD  = 2'd1,
    DIR_STOP = 2'd2
  } dir_t;

  typedef enum logic {
    CFG_SPEED_OFFSET = 1'b0,
    CFG_SPEED_LIMIT  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic x_pos;
    logic y_neg;
    logic y_dom;
    logic x_dom;
  } steer_t;

endpackage

`default_nettype wire

>>> hdl/jddm_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module jddm_sqrt_pipe
  import jddm_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF,
  parameter int SIDE_W     = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [2*AXIS_WIDTH-1:0]        in_sum,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic [AXIS_WIDTH+FRAC_BITS-1:0] out_root,
  output logic [SIDE_W-1:0]              out_side
);

  localparam int RW = AXIS_WIDTH + FRAC_BITS;
  localparam int NW = 2 * RW;

  logic [NW:0]       rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [SIDE_W-1:0] side_r [RW];
  logic [RW-1:0]     vld_r;

  // one root bit per stage, msb first
  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int B = RW - 1 - k;
    logic [NW:0]       rem_p;
    logic [NW:0]       trial;
    logic [RW-1:0]     root_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;

    if (k == 0) begin : g_in
      assign rem_p  = {1'b0, in_sum, {(2*FRAC_BITS){1'b0}}};
      assign root_p = '0;
      assign side_p = in_side;
      assign vld_p  = in_valid;
    end else begin : g_chain
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign side_p = side_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    // (root + 2^B)^2 - root^2, root has no bits at or below B
    assign trial = ((NW+1)'(root_p) << (B + 1)) | ((NW+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_p;
      if (rem_p >= trial) begin
        rem_r[k]  <= rem_p - trial;
        root_r[k] <= root_p | (RW'(1) << B);
      end else begin
        rem_r[k]  <= rem_p;
        root_r[k] <= root_p;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

`default_nettype wire

>>> hdl/jddm_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module jddm_div_pipe
  import jddm_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF,
  parameter int SIDE_W     = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [DUTY_W+AXIS_WIDTH-1:0] in_num,
  input  logic [AXIS_WIDTH-1:0]        in_den,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  output logic [DUTY_W-1:0]            out_quot,
  output logic [SIDE_W-1:0]            out_side
);

  localparam int NUMW = DUTY_W + AXIS_WIDTH;

  logic [NUMW-1:0]       rem_r  [DIV_STEPS];
  logic [AXIS_WIDTH-1:0] den_r  [DIV_STEPS];
  logic [DUTY_W-1:0]     quot_r [DIV_STEPS];
  logic [SIDE_W-1:0]     side_r [DIV_STEPS];
  logic [DIV_STEPS-1:0]  vld_r;

  // restoring division, quotient known to fit in DUTY_W bits
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
    localparam int B = DIV_STEPS - 1 - k;
    logic [NUMW-1:0]       rem_p;
    logic [NUMW-1:0]       trial;
    logic [AXIS_WIDTH-1:0] den_p;
    logic [DUTY_W-1:0]     quot_p;
    logic [SIDE_W-1:0]     side_p;
    logic                  vld_p;

    if (k == 0) begin : g_in
      assign rem_p  = in_num;
      assign den_p  = in_den;
      assign quot_p = '0;
      assign side_p = in_side;
      assign vld_p  = in_valid;
    end else begin : g_chain
      assign rem_p  = rem_r[k-1];
      assign den_p  = den_r[k-1];
      assign quot_p = quot_r[k-1];
      assign side_p = side_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    assign trial = NUMW'(den_p) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      den_r[k]  <= den_p;
      side_r[k] <= side_p;
      if (rem_p >= trial) begin
        rem_r[k]  <= rem_p - trial;
        quot_r[k] <= quot_p | (DUTY_W'(1) << B);
      end else begin
        rem_r[k]  <= rem_p;
        quot_r[k] <= quot_p;
      end
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_quot  = quot_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> hdl/joystick_differential_drive_mixer.sv
// Joystick differential drive mixer.
// Input: pulse start with a signed stick sample on in_stick_x / in_stick_y; the
// beat is taken on any clock edge where start is high and busy is low. busy is
// never raised, so one beat can be taken every cycle.
// Output: out_valid strobes for one cycle with the left and right wheel
// direction (0 forward, 1 backward, 2 stop) and duty. Results come out in
// input order, one per input beat.
// The pipeline is three front stages (abs, squares, sum), one square root
// stage per root bit (AXIS_WIDTH + 8 of them), gain multiply, offset and
// limit, inner wheel product, eight divider stages (one quotient bit each)
// and the output register.
// Throughput is one beat per cycle.
// Configuration: cfg_we writes cfg_wdata to speed_offset (index 0) or
// speed_limit (index 1); write only while no beat is in flight.
// Reset (synchronous, rst_n low) clears every valid bit, so nothing in flight
// comes out, and restores speed_offset to 50 and speed_limit to 100.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module joystick_differential_drive_mixer
  import jddm_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [AXIS_WIDTH-1:0] in_stick_x,
  input  logic signed [AXIS_WIDTH-1:0] in_stick_y,
  output logic                         out_valid,
  output logic [1:0]                   out_left_direction,
  output logic [1:0]                   out_right_direction,
  output logic [DUTY_W-1:0]            out_left_duty,
  output logic [DUTY_W-1:0]            out_right_duty,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [DUTY_W-1:0]            cfg_wdata
);

  localparam int RW      = AXIS_WIDTH + FRAC_BITS;
  localparam int SW      = 2 * AXIS_WIDTH;
  localparam int MW      = GAIN_W + RW;
  localparam int NUMW    = DUTY_W + AXIS_WIDTH;
  localparam int SPW     = ((AXIS_WIDTH > DUTY_W) ? AXIS_WIDTH : DUTY_W) + 1;
  localparam int LATENCY = RW + DIV_STEPS + 7;

  typedef struct packed {
    steer_t                steer;
    logic [AXIS_WIDTH-1:0] diff;
    logic [AXIS_WIDTH-1:0] ay;
  } sq_side_t;

  typedef struct packed {
    steer_t            steer;
    logic [DUTY_W-1:0] speed;
  } div_side_t;

  localparam int SQ_SIDE_W  = $bits(sq_side_t);
  localparam int DIV_SIDE_W = $bits(div_side_t);

  // configuration registers
  logic [DUTY_W-1:0] speed_offset_r;
  logic [DUTY_W-1:0] speed_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_offset_r <= OFFSET_RST;
      speed_limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPEED_OFFSET: speed_offset_r <= cfg_wdata;
        CFG_SPEED_LIMIT:  speed_limit_r  <= cfg_wdata;
        default:          speed_limit_r  <= speed_limit_r;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage: absolute values
  logic                  s0_vld_r;
  logic [AXIS_WIDTH-1:0] ax_r, ay_r;
  logic                  x_pos_r, y_neg_r;
  logic [AXIS_WIDTH-1:0] ax_nxt, ay_nxt;

  // most negative value gives 2^(w-1) as unsigned, no wrap
  assign ax_nxt = in_stick_x[AXIS_WIDTH-1] ? AXIS_WIDTH'(~$unsigned(in_stick_x) + 1'b1)
                                           : $unsigned(in_stick_x);
  assign ay_nxt = in_stick_y[AXIS_WIDTH-1] ? AXIS_WIDTH'(~$unsigned(in_stick_y) + 1'b1)
                                           : $unsigned(in_stick_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    x_pos_r <= !in_stick_x[AXIS_WIDTH-1] && (in_stick_x != '0);
    y_neg_r <= in_stick_y[AXIS_WIDTH-1];
  end

  // stage: squares and axis compare
  logic          s1_vld_r;
  logic [SW-1:0] sqx_r, sqy_r;
  sq_side_t      s1_side_r;
  sq_side_t      s1_side_nxt;

  always_comb begin
    s1_side_nxt.steer.x_pos = x_pos_r;
    s1_side_nxt.steer.y_neg = y_neg_r;
    s1_side_nxt.steer.y_dom = ay_r > ax_r;
    s1_side_nxt.steer.x_dom = ax_r > ay_r;
    s1_side_nxt.diff        = ay_r - ax_r;
    s1_side_nxt.ay          = ay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r     <= SW'(ax_r) * SW'(ax_r);
    sqy_r     <= SW'(ay_r) * SW'(ay_r);
    s1_side_r <= s1_side_nxt;
  end

  // stage: sum of squares, fits since each square is at most 2^(2w-2)
  logic          s2_vld_r;
  logic [SW-1:0] sum_r;
  sq_side_t      s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sqx_r + sqy_r;
    s2_side_r <= s1_side_r;
  end

  // square root with 8 fraction bits
  logic                 sq_vld;
  logic [RW-1:0]        sq_root;
  logic [SQ_SIDE_W-1:0] sq_side_vec;
  sq_side_t             sq_side;

  jddm_sqrt_pipe #(
    .AXIS_WIDTH (AXIS_WIDTH),
    .SIDE_W     (SQ_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld_r),
    .in_sum    (sum_r),
    .in_side   (s2_side_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side_vec)
  );

  assign sq_side = sq_side_t'(sq_side_vec);

  // stage: gain multiply
  logic          s3_vld_r;
  logic [MW-1:0] mul_r;
  sq_side_t      s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    mul_r     <= MW'(GAIN_Q16) * MW'(sq_root);
    s3_side_r <= sq_side;
  end

  // stage: offset and limit
  logic              s4_vld_r;
  logic [DUTY_W-1:0] speed_r;
  sq_side_t          s4_side_r;
  logic [SPW-1:0]    spd_sum;
  logic [DUTY_W-1:0] speed_nxt;

  assign spd_sum   = SPW'(mul_r[MW-1:GAIN_W+FRAC_BITS]) + SPW'(speed_offset_r);
  assign speed_nxt = (spd_sum > SPW'(speed_limit_r)) ? speed_limit_r : spd_sum[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    speed_r   <= speed_nxt;
    s4_side_r <= s3_side_r;
  end

  // stage: inner wheel numerator speed * (max - min)
  logic                  s5_vld_r;
  logic [NUMW-1:0]       num_r;
  logic [AXIS_WIDTH-1:0] den_r;
  div_side_t             s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    num_r           <= NUMW'(speed_r) * NUMW'(s4_side_r.diff);
    den_r           <= s4_side_r.ay;
    s5_side_r.steer <= s4_side_r.steer;
    s5_side_r.speed <= speed_r;
  end

  // divide by max, only used when y dominates so max is nonzero
  logic                  dv_vld;
  logic [DUTY_W-1:0]     dv_quot;
  logic [DIV_SIDE_W-1:0] dv_side_vec;
  div_side_t             dv_side;

  jddm_div_pipe #(
    .AXIS_WIDTH (AXIS_WIDTH),
    .SIDE_W     (DIV_SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_vld_r),
    .in_num    (num_r),
    .in_den    (den_r),
    .in_side   (s5_side_r),
    .out_valid (dv_vld),
    .out_quot  (dv_quot),
    .out_side  (dv_side_vec)
  );

  assign dv_side = div_side_t'(dv_side_vec);

  // output stage: steering
  logic              out_valid_r;
  dir_t              ldir_r, rdir_r;
  logic [DUTY_W-1:0] lduty_r, rduty_r;
  dir_t              ldir_nxt, rdir_nxt;
  logic [DUTY_W-1:0] lduty_nxt, rduty_nxt;

  always_comb begin
    ldir_nxt  = DIR_STOP;
    rdir_nxt  = DIR_STOP;
    lduty_nxt = '0;
    rduty_nxt = '0;
    if (dv_side.steer.y_dom) begin
      ldir_nxt = dv_side.steer.y_neg ? DIR_FWD : DIR_BWD;
      rdir_nxt = ldir_nxt;
      // right wheel is inner going forward-right or backward-left
      if (dv_side.steer.x_pos == dv_side.steer.y_neg) begin
        lduty_nxt = dv_side.speed;
        rduty_nxt = dv_quot;
      end else begin
        lduty_nxt = dv_quot;
        rduty_nxt = dv_side.speed;
      end
    end else if (dv_side.steer.x_dom) begin
      lduty_nxt = dv_side.speed;
      rduty_nxt = dv_side.speed;
      ldir_nxt  = dv_side.steer.x_pos ? DIR_FWD : DIR_BWD;
      rdir_nxt  = dv_side.steer.x_pos ? DIR_BWD : DIR_FWD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    ldir_r  <= ldir_nxt;
    rdir_r  <= rdir_nxt;
    lduty_r <= lduty_nxt;
    rduty_r <= rduty_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_left_direction  = ldir_r;
  assign out_right_direction = rdir_r;
  assign out_left_duty       = lduty_r;
  assign out_right_duty      = rduty_r;

  `ASSERT_DELAY(a_latency, start && !busy, LATENCY, out_valid, "beat lost in pipeline")
  `ASSERT_IMPL(a_stop_both, out_valid && out_left_direction == DIR_STOP, out_right_direction == DIR_STOP && out_left_duty == '0 && out_right_duty == '0, "stop not symmetric")
  `ASSERT_IMPL(a_rotate_duty, out_valid && out_left_direction != out_right_direction, out_left_duty == out_right_duty, "rotation duties differ")

endmodule

`default_nettype wire
